FILE: src/ltc_pkg.sv
`default_nettype none
package ltc_pkg;

   localparam int MAX_SEGMENTS = 64;
   localparam int SEG_W        = $clog2(MAX_SEGMENTS);
   localparam int DIVIDEND_W   = 48;
   localparam int DIVISOR_W    = 32;
   localparam int ITER_W       = $clog2(DIVIDEND_W);

   localparam logic [2:0] CSR_SECTOR_BYTES  = 3'd0;
   localparam logic [2:0] CSR_TRACK_SECTORS = 3'd1;
   localparam logic [2:0] CSR_HEAD_COUNT    = 3'd2;
   localparam logic [2:0] CSR_MAX_CYLINDER  = 3'd3;
   localparam logic [2:0] CSR_HIDDEN_BASE   = 3'd4;

   localparam logic [1:0] OP_INVALID = 2'd3;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_MISALIGNED = 3'd1,
      STATUS_CYLINDER   = 3'd2,
      STATUS_PAST_END   = 3'd3,
      STATUS_BAD_OP     = 3'd4,
      STATUS_OVERFLOW   = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      STEP_NONE,
      STEP_START,
      STEP_SAVE_PHYS,
      STEP_SAVE_LEFT,
      STEP_SAVE_CYL,
      STEP_SAVE_HEAD,
      STEP_SEGMENT,
      STEP_ADVANCE
   } step_type;

   typedef struct packed {
      step_type   step;
      logic       err_load;
      status_type err_status;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic sb_zero;
      logic misaligned;
      logic geo_zero;
      logic quo_over;
      logic cyl_over;
      logic op_bad;
      logic seg_last;
      logic seg_full;
   } stat_type;

endpackage
`default_nettype wire

FILE: src/ltc_div.sv
`default_nettype none
module ltc_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [ltc_pkg::DIVIDEND_W-1:0] dividend,
   input  wire logic [ltc_pkg::DIVISOR_W-1:0]  divisor,
   output logic                                busy,
   output logic      [ltc_pkg::DIVIDEND_W-1:0] quotient,
   output logic      [ltc_pkg::DIVISOR_W-1:0]  remainder
);
   import ltc_pkg::*;

   logic                  busy_ff, busy_in;
   logic [ITER_W-1:0]     iter_ff, iter_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W:0]    rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvsr_ff, dvsr_in;
   logic [DIVISOR_W:0]    trial;

   // One quotient bit per cycle, restoring form.
   always_comb begin
      busy_in = busy_ff;
      iter_in = iter_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      trial   = {rem_ff[DIVISOR_W-1:0], quo_ff[DIVIDEND_W-1]};
      if (start) begin
         busy_in = 1'b1;
         iter_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvsr_in = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvsr_ff}) begin
            rem_in = trial - {1'b0, dvsr_ff};
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         iter_in = iter_ff + 1'b1;
         if (iter_ff == ITER_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      iter_ff <= iter_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[DIVISOR_W-1:0];
endmodule
`default_nettype wire

FILE: src/ltc_datapath.sv
`default_nettype none
module ltc_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write,
   input  wire logic [2:0]        csr_index,
   input  wire logic [31:0]       csr_data,
   input  wire logic [47:0]       req_byte_offset,
   input  wire logic [30:0]       req_byte_count,
   input  wire logic [1:0]        req_operation,
   input  wire ltc_pkg::cmd_type  cmd,
   output ltc_pkg::stat_type      stat,
   output logic      [15:0]       rsp_cylinder,
   output logic      [15:0]       rsp_head,
   output logic      [15:0]       rsp_first_sector,
   output logic      [15:0]       rsp_sector_count,
   output logic      [31:0]       rsp_segment_bytes,
   output logic      [30:0]       rsp_buffer_offset,
   output logic      [1:0]        rsp_command,
   output logic      [2:0]        rsp_status,
   output logic                   rsp_last
);
   import ltc_pkg::*;

   logic [15:0] sb_ff, ts_ff, hc_ff, maxc_ff;
   logic [31:0] hidden_ff;

   logic [30:0] cnt_ff;
   logic [1:0]  op_ff;
   logic        mis_ff;
   logic [31:0] phys_ff;
   logic [30:0] left_ff;
   logic [31:0] cyl_ff;
   logic [15:0] head_ff, first_ff;
   logic [30:0] bufpos_ff;
   logic [SEG_W-1:0] k_ff;

   logic [15:0] o_cyl_ff, o_head_ff, o_first_ff, o_n_ff;
   logic [31:0] o_bytes_ff;
   logic [30:0] o_buf_ff;
   logic [1:0]  o_cmd_ff;
   logic [2:0]  o_status_ff;
   logic        o_last_ff;

   logic                  div_start;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic [DIVISOR_W-1:0]  div_divisor;
   logic                  div_busy;
   logic [DIVIDEND_W-1:0] div_quo;
   logic [DIVISOR_W-1:0]  div_rem;

   logic [15:0] avail, seg_n;
   logic [16:0] head_next;

   ltc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Divider operand selection for each stage of the address split.
   always_comb begin
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      unique case (cmd.step)
         STEP_START: begin
            div_start    = 1'b1;
            div_dividend = req_byte_offset;
            div_divisor  = {16'd0, sb_ff};
         end
         STEP_SAVE_PHYS: begin
            div_start    = 1'b1;
            div_dividend = {17'd0, cnt_ff};
            div_divisor  = {16'd0, sb_ff};
         end
         STEP_SAVE_LEFT: begin
            div_start    = 1'b1;
            div_dividend = {16'd0, phys_ff};
            div_divisor  = ts_ff * hc_ff;
         end
         STEP_SAVE_CYL: begin
            div_start    = 1'b1;
            div_dividend = {16'd0, div_rem};
            div_divisor  = {16'd0, ts_ff};
         end
         default: begin
         end
      endcase
   end

   assign avail     = ts_ff - first_ff;
   assign seg_n     = ({15'd0, avail} > left_ff) ? left_ff[15:0] : avail;
   assign head_next = {1'b0, head_ff} + 17'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sb_ff     <= 16'd512;
         ts_ff     <= 16'd63;
         hc_ff     <= 16'd255;
         maxc_ff   <= 16'd1023;
         hidden_ff <= 32'd0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SECTOR_BYTES:  sb_ff     <= csr_data[15:0];
            CSR_TRACK_SECTORS: ts_ff     <= csr_data[15:0];
            CSR_HEAD_COUNT:    hc_ff     <= csr_data[15:0];
            CSR_MAX_CYLINDER:  maxc_ff   <= csr_data[15:0];
            CSR_HIDDEN_BASE:   hidden_ff <= csr_data;
            default: begin
            end
         endcase
      end

      unique case (cmd.step)
         STEP_START: begin
            cnt_ff <= req_byte_count;
            op_ff  <= req_operation;
         end
         STEP_SAVE_PHYS: begin
            phys_ff <= div_quo[31:0] + hidden_ff;
            mis_ff  <= (div_rem != '0);
         end
         STEP_SAVE_LEFT: begin
            left_ff <= div_quo[30:0];
         end
         STEP_SAVE_CYL: begin
            cyl_ff <= div_quo[31:0];
         end
         STEP_SAVE_HEAD: begin
            head_ff   <= div_quo[15:0];
            first_ff  <= div_rem[15:0];
            bufpos_ff <= '0;
            k_ff      <= '0;
         end
         STEP_SEGMENT: begin
            o_cyl_ff    <= cyl_ff[15:0];
            o_head_ff   <= head_ff;
            o_first_ff  <= first_ff;
            o_n_ff      <= seg_n;
            o_bytes_ff  <= seg_n * sb_ff;
            o_buf_ff    <= bufpos_ff;
            o_cmd_ff    <= op_ff;
            o_status_ff <= STATUS_OK;
            o_last_ff   <= (left_ff == {15'd0, seg_n});
            left_ff     <= left_ff - {15'd0, seg_n};
         end
         STEP_ADVANCE: begin
            bufpos_ff <= bufpos_ff + o_bytes_ff[30:0];
            first_ff  <= '0;
            k_ff      <= k_ff + 1'b1;
            if (head_next >= {1'b0, hc_ff}) begin
               head_ff <= '0;
               cyl_ff  <= cyl_ff + 32'd1;
            end else begin
               head_ff <= head_next[15:0];
            end
         end
         default: begin
         end
      endcase

      if (cmd.err_load) begin
         o_cyl_ff    <= '0;
         o_head_ff   <= '0;
         o_first_ff  <= '0;
         o_n_ff      <= '0;
         o_bytes_ff  <= '0;
         o_buf_ff    <= '0;
         o_cmd_ff    <= '0;
         o_status_ff <= cmd.err_status;
         o_last_ff   <= 1'b1;
      end
   end

   always_comb begin
      stat.div_busy   = div_busy;
      stat.sb_zero    = (sb_ff == '0);
      stat.misaligned = mis_ff || (div_rem != '0);
      stat.geo_zero   = (ts_ff == '0) || (hc_ff == '0);
      stat.quo_over   = (div_quo > {32'd0, maxc_ff});
      stat.cyl_over   = (cyl_ff > {16'd0, maxc_ff});
      stat.op_bad     = (op_ff == OP_INVALID);
      stat.seg_last   = o_last_ff;
      stat.seg_full   = ({{(32-SEG_W){1'b0}}, k_ff} >= 32'(MAX_SEGMENTS - 1));
   end

   assign rsp_cylinder      = o_cyl_ff;
   assign rsp_head          = o_head_ff;
   assign rsp_first_sector  = o_first_ff;
   assign rsp_sector_count  = o_n_ff;
   assign rsp_segment_bytes = o_bytes_ff;
   assign rsp_buffer_offset = o_buf_ff;
   assign rsp_command       = o_cmd_ff;
   assign rsp_status        = o_status_ff;
   assign rsp_last          = o_last_ff;
endmodule
`default_nettype wire

FILE: src/ltc_ctrl.sv
`default_nettype none
module ltc_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire ltc_pkg::stat_type stat,
   output ltc_pkg::cmd_type       cmd
);
   import ltc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DIV_OFF, S_DIV_CNT, S_DIV_CYL, S_DIV_HEAD,
      S_SEG, S_EMIT, S_CHECK
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   always_comb begin
      state_in       = state_ff;
      valid_in       = valid_ff;
      cmd.step       = STEP_NONE;
      cmd.err_load   = 1'b0;
      cmd.err_status = STATUS_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (stat.sb_zero) begin
                  cmd.err_load   = 1'b1;
                  cmd.err_status = STATUS_MISALIGNED;
                  state_in       = S_EMIT;
                  valid_in       = 1'b1;
               end else begin
                  cmd.step = STEP_START;
                  state_in = S_DIV_OFF;
               end
            end
         end
         S_DIV_OFF: begin
            if (!stat.div_busy) begin
               cmd.step = STEP_SAVE_PHYS;
               state_in = S_DIV_CNT;
            end
         end
         S_DIV_CNT: begin
            if (!stat.div_busy) begin
               priority if (stat.misaligned) begin
                  cmd.err_load   = 1'b1;
                  cmd.err_status = STATUS_MISALIGNED;
               end else if (stat.geo_zero) begin
                  cmd.err_load   = 1'b1;
                  cmd.err_status = STATUS_CYLINDER;
               end else begin
                  cmd.step = STEP_SAVE_LEFT;
               end
               state_in = cmd.err_load ? S_EMIT : S_DIV_CYL;
               valid_in = cmd.err_load;
            end
         end
         S_DIV_CYL: begin
            if (!stat.div_busy) begin
               priority if (stat.quo_over) begin
                  cmd.err_load   = 1'b1;
                  cmd.err_status = STATUS_CYLINDER;
               end else if (stat.op_bad) begin
                  cmd.err_load   = 1'b1;
                  cmd.err_status = STATUS_BAD_OP;
               end else begin
                  cmd.step = STEP_SAVE_CYL;
               end
               state_in = cmd.err_load ? S_EMIT : S_DIV_HEAD;
               valid_in = cmd.err_load;
            end
         end
         S_DIV_HEAD: begin
            if (!stat.div_busy) begin
               cmd.step = STEP_SAVE_HEAD;
               state_in = S_SEG;
            end
         end
         S_SEG: begin
            cmd.step = STEP_SEGMENT;
            state_in = S_EMIT;
            valid_in = 1'b1;
         end
         S_EMIT: begin
            if (!rsp_stall) begin
               valid_in = 1'b0;
               if (stat.seg_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.step = STEP_ADVANCE;
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            priority if (stat.cyl_over) begin
               cmd.err_load   = 1'b1;
               cmd.err_status = STATUS_PAST_END;
            end else if (stat.seg_full) begin
               cmd.err_load   = 1'b1;
               cmd.err_status = STATUS_OVERFLOW;
            end else begin
               cmd.step = STEP_NONE;
            end
            state_in = cmd.err_load ? S_EMIT : S_SEG;
            valid_in = cmd.err_load;
         end
         default: begin
            state_in = S_IDLE;
            valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;
endmodule
`default_nettype wire

FILE: src/lba_to_chs_track_splitter_core.sv
`default_nettype none
// Splits one disk transfer request into track segments in cylinder, head and
// zero-based sector form. A request is accepted only while the block is idle;
// it then runs four divisions through one shared bit-serial divider (start
// sector, sector count, cylinder, head). For each track segment after that,
// the block forms the segment, hands the result over, which the result side
// may stall, then checks for the end of the disk or too many segments.
// Errors (zero sector size, misaligned offset or count, zero track or head
// count, cylinder out of range, bad operation, running past the last cylinder,
// too many segments) end the request with a single zeroed result that carries
// the status and has last set.
module lba_to_chs_track_splitter_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [47:0] req_byte_offset,
   input  wire logic [30:0] req_byte_count,
   input  wire logic [1:0]  req_operation,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [15:0] rsp_cylinder,
   output logic      [15:0] rsp_head,
   output logic      [15:0] rsp_first_sector,
   output logic      [15:0] rsp_sector_count,
   output logic      [31:0] rsp_segment_bytes,
   output logic      [30:0] rsp_buffer_offset,
   output logic      [1:0]  rsp_command,
   output logic      [2:0]  rsp_status,
   output logic             rsp_last
);
   import ltc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // The controller sequences the divisions and the segment loop.
   ltc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the registers, the divider and the result register.
   ltc_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_byte_offset   (req_byte_offset),
      .req_byte_count    (req_byte_count),
      .req_operation     (req_operation),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_cylinder      (rsp_cylinder),
      .rsp_head          (rsp_head),
      .rsp_first_sector  (rsp_first_sector),
      .rsp_sector_count  (rsp_sector_count),
      .rsp_segment_bytes (rsp_segment_bytes),
      .rsp_buffer_offset (rsp_buffer_offset),
      .rsp_command       (rsp_command),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );
endmodule
`default_nettype wire

FILE: sim/tb_lba_to_chs_track_splitter_core.sv
`timescale 1ns / 100ps
// Self-checking bench for the track splitter. Requests are driven through the
// valid/stall handshake with random gaps. Every accepted request is expanded by a
// local geometry model into the list of track segments it should produce.
// Each returned segment is compared field by field with the oldest one of them.
module tb_lba_to_chs_track_splitter_core;
   import ltc_pkg::*;

   localparam int IDLE_LIMIT = 6000;

   // One expected track segment, at the widths of the result ports.
   typedef struct {
      logic [15:0] cylinder;
      logic [15:0] head;
      logic [15:0] first_sector;
      logic [15:0] sector_count;
      logic [31:0] segment_bytes;
      logic [30:0] buffer_offset;
      logic [1:0]  command;
      status_type  status;
      logic        last;
   } segment_type;

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;
   logic        req_valid;
   logic        req_stall;
   logic [47:0] req_byte_offset;
   logic [30:0] req_byte_count;
   logic [1:0]  req_operation;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_cylinder;
   logic [15:0] rsp_head;
   logic [15:0] rsp_first_sector;
   logic [15:0] rsp_sector_count;
   logic [31:0] rsp_segment_bytes;
   logic [30:0] rsp_buffer_offset;
   logic [1:0]  rsp_command;
   logic [2:0]  rsp_status;
   logic        rsp_last;

   // Local copy of the geometry registers, updated together with the block.
   logic [15:0] geo_sector_bytes;
   logic [15:0] geo_track_sectors;
   logic [15:0] geo_head_count;
   logic [15:0] geo_max_cylinder;
   logic [31:0] geo_hidden_base;

   segment_type segment_q[$];
   int          error_count;
   int          idle_cycles;
   int          stall_left;
   bit          no_gaps;

   lba_to_chs_track_splitter_core dut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_byte_offset(req_byte_offset), .req_byte_count(req_byte_count),
      .req_operation(req_operation),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_cylinder(rsp_cylinder), .rsp_head(rsp_head),
      .rsp_first_sector(rsp_first_sector), .rsp_sector_count(rsp_sector_count),
      .rsp_segment_bytes(rsp_segment_bytes), .rsp_buffer_offset(rsp_buffer_offset),
      .rsp_command(rsp_command), .rsp_status(rsp_status), .rsp_last(rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int draw_gap();
      if (no_gaps) return 0;
      return $urandom_range(0, 16);
   endfunction

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $time, what);
      error_count++;
   endtask

   // Pushes one result onto the expected list.
   function automatic void push_segment(input logic [31:0] cyl, input logic [31:0] hd,
                                        input logic [31:0] first, input logic [31:0] cnt,
                                        input logic [31:0] bytes, input logic [31:0] bufpos,
                                        input logic [1:0] cmd, input status_type st,
                                        input logic last);
      segment_type s;
      s.cylinder      = cyl[15:0];
      s.head          = hd[15:0];
      s.first_sector  = first[15:0];
      s.sector_count  = cnt[15:0];
      s.segment_bytes = bytes;
      s.buffer_offset = bufpos[30:0];
      s.command       = cmd;
      s.status        = st;
      s.last          = last;
      segment_q.push_back(s);
   endfunction

   function automatic void push_error(input status_type st);
      push_segment(0, 0, 0, 0, 0, 0, 2'd0, st, 1'b1);
   endfunction

   // Expands one request into its track segments under the current geometry.
   function automatic void predict_segments(input logic [47:0] offset,
                                            input logic [30:0] count,
                                            input logic [1:0] op);
      logic [31:0] phys, per_cyl, cyl, rem, hd, first, left, bufpos;
      logic [31:0] avail, n, bytes;
      logic [47:0] sec_full;
      int k;
      if (geo_sector_bytes == 0 || offset % geo_sector_bytes != 0 ||
          count % geo_sector_bytes != 0) begin
         push_error(STATUS_MISALIGNED);
         return;
      end
      if (geo_track_sectors == 0 || geo_head_count == 0) begin
         push_error(STATUS_CYLINDER);
         return;
      end
      sec_full = offset / geo_sector_bytes;
      phys     = sec_full[31:0] + geo_hidden_base;
      per_cyl  = 32'(geo_track_sectors) * 32'(geo_head_count);
      cyl      = phys / per_cyl;
      // The cylinder is compared at full width, before it is cut to 16 bits.
      if (cyl > 32'(geo_max_cylinder)) begin
         push_error(STATUS_CYLINDER);
         return;
      end
      if (op == OP_INVALID) begin
         push_error(STATUS_BAD_OP);
         return;
      end
      rem    = phys % per_cyl;
      hd     = rem / geo_track_sectors;
      first  = rem % geo_track_sectors;
      left   = 32'(count) / geo_sector_bytes;
      bufpos = 0;
      k      = 0;
      forever begin
         avail = 32'(geo_track_sectors) - first;
         n     = (avail > left) ? left : avail;
         bytes = n * geo_sector_bytes;
         left  = left - n;
         push_segment(cyl, hd, first, n, bytes, bufpos, op, STATUS_OK, left == 0);
         k++;
         if (left == 0) return;
         bufpos = bufpos + bytes;
         first  = 0;
         hd     = hd + 1;
         if (hd >= geo_head_count) begin
            hd  = 0;
            cyl = cyl + 1;
         end
         if (cyl > 32'(geo_max_cylinder)) begin
            push_error(STATUS_PAST_END);
            return;
         end
         if (k >= MAX_SEGMENTS - 1) begin
            push_error(STATUS_OVERFLOW);
            return;
         end
      end
   endfunction

   // Result side: checks each accepted segment, draws the next stall, and
   // runs the watchdog on cycles where neither side moves a request or result.
   always @(posedge clock) begin
      segment_type s;
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) moved = 1'b1;
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (segment_q.size() == 0) begin
               report("result with no expected segment");
            end else begin
               s = segment_q.pop_front();
               if (rsp_cylinder !== s.cylinder)
                  report($sformatf("cylinder %0d want %0d", rsp_cylinder, s.cylinder));
               if (rsp_head !== s.head)
                  report($sformatf("head %0d want %0d", rsp_head, s.head));
               if (rsp_first_sector !== s.first_sector)
                  report($sformatf("first_sector %0d want %0d",
                                   rsp_first_sector, s.first_sector));
               if (rsp_sector_count !== s.sector_count)
                  report($sformatf("sector_count %0d want %0d",
                                   rsp_sector_count, s.sector_count));
               if (rsp_segment_bytes !== s.segment_bytes)
                  report($sformatf("segment_bytes %0d want %0d",
                                   rsp_segment_bytes, s.segment_bytes));
               if (rsp_buffer_offset !== s.buffer_offset)
                  report($sformatf("buffer_offset %0d want %0d",
                                   rsp_buffer_offset, s.buffer_offset));
               if (rsp_command !== s.command)
                  report($sformatf("command %0d want %0d", rsp_command, s.command));
               if (rsp_status !== s.status)
                  report($sformatf("status %0d want %0d", rsp_status, s.status));
               if (rsp_last !== s.last)
                  report($sformatf("last %0d want %0d", rsp_last, s.last));
            end
            stall_left = draw_gap();
         end else if (stall_left > 0) begin
            stall_left--;
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
      rsp_stall <= (stall_left != 0);
   end

   // Waits until the block has handed back every expected segment, then lets
   // it settle back to idle before the registers change.
   task automatic wait_drained();
      while (segment_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Writes all five geometry registers on consecutive edges.
   task automatic set_geometry(input logic [15:0] sb, input logic [15:0] ts,
                               input logic [15:0] hc, input logic [15:0] mc,
                               input logic [31:0] hb);
      wait_drained();
      csr_write <= 1'b1;
      csr_index <= CSR_SECTOR_BYTES;  csr_data <= 32'(sb); @(posedge clock);
      csr_index <= CSR_TRACK_SECTORS; csr_data <= 32'(ts); @(posedge clock);
      csr_index <= CSR_HEAD_COUNT;    csr_data <= 32'(hc); @(posedge clock);
      csr_index <= CSR_MAX_CYLINDER;  csr_data <= 32'(mc); @(posedge clock);
      csr_index <= CSR_HIDDEN_BASE;   csr_data <= hb;      @(posedge clock);
      csr_write <= 1'b0;
      geo_sector_bytes  = sb;
      geo_track_sectors = ts;
      geo_head_count    = hc;
      geo_max_cylinder  = mc;
      geo_hidden_base   = hb;
   endtask

   // Sends one request and holds it until accepted. Valid is dropped in the
   // accepting step, so the next request always rises on a later edge.
   task automatic send_request(input logic [47:0] offset, input logic [30:0] count,
                               input logic [1:0] op);
      int gap;
      gap = draw_gap();
      @(posedge clock);
      repeat (gap) @(posedge clock);
      req_valid       <= 1'b1;
      req_byte_offset <= offset;
      req_byte_count  <= count;
      req_operation   <= op;
      do @(posedge clock); while (req_stall);
      predict_segments(offset, count, op);
      req_valid <= 1'b0;
   endtask

   // Request at a given physical sector (hidden sectors subtracted back out).
   task automatic send_at_sector(input logic [63:0] target, input logic [31:0] sectors,
                                 input logic [1:0] op);
      logic [31:0] sec;
      logic [63:0] bytes;
      sec   = target[31:0] - geo_hidden_base;
      bytes = 64'(sectors) * geo_sector_bytes;
      send_request(48'(64'(sec) * geo_sector_bytes), bytes[30:0], op);
   endtask

   // Reset geometry: zero count, track crossing, every operation, the error
   // cases, past end, segment overflow and the field extremes.
   task automatic test_default_geometry();
      send_request(48'd0, 31'd0, 2'd0);
      send_request(48'd0, 31'd512, 2'd0);
      send_request(48'(62 * 512), 31'(3 * 512), 2'd1);
      send_request(48'(63 * 255 * 512), 31'(300 * 512), 2'd2);
      send_request(48'd512, 31'd512, OP_INVALID);
      send_request(48'd513, 31'd512, 2'd0);
      send_request(48'd1024, 31'd100, 2'd1);
      send_request(48'(64'd1024 * 63 * 255 * 512), 31'd512, 2'd0);
      send_request(48'(64'd1024 * 63 * 255 * 512 - 512), 31'(2 * 512), 2'd0);
      send_request(48'd0, 31'(64 * 63 * 512), 2'd2);
      send_request(48'hFFFF_FFFF_FFFF, 31'h7FFF_FFFF, 2'd3);
      send_request(48'hFFFF_FFFF_FE00, 31'h7FFF_FE00, 2'd0);
   endtask

   // Extreme geometry: one-byte sectors, one sector per track, one head, top hidden
   // base, then top max cylinder, then every register at its maximum.
   task automatic test_extreme_geometry();
      no_gaps = 1'b1;
      set_geometry(16'd1, 16'd1, 16'd1, 16'd0, 32'hFFFF_FFFF);
      send_request(48'd1, 31'd1, 2'd0);
      send_request(48'd1, 31'd2, 2'd1);
      send_request(48'd0, 31'd1, 2'd2);
      no_gaps = 1'b0;
      set_geometry(16'd1, 16'd1, 16'd1, 16'd65535, 32'd0);
      send_request(48'd7, 31'h7FFF_FFFF, 2'd1);
      send_request(48'd65535, 31'd3, 2'd0);
      set_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(48'hFFFF_FFFF_FFFF - 48'hFFFF, 31'(3 * 65535), 2'd2);
      send_request(48'd0, 31'(2 * 65535), 2'd0);
   endtask

   // One phase of random requests under a random geometry. Most are aligned
   // and land inside or just past the disk; the rest are misaligned or noise.
   task automatic test_random_phase(input int items);
      logic [63:0] per_cyl, target, span;
      logic [31:0] sectors;
      logic [1:0]  op;
      int kind;
      set_geometry($urandom_range(0, 3) == 0 ? 16'($urandom_range(1, 65535))
                                             : 16'($urandom_range(1, 8)),
                   16'($urandom_range(1, 20)), 16'($urandom_range(1, 6)),
                   16'($urandom_range(0, 40)),
                   $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 200)));
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (items) begin
         per_cyl = 64'(geo_track_sectors) * geo_head_count;
         span    = (64'(geo_max_cylinder) + 2) * per_cyl;
         target  = {$urandom, $urandom} % span;
         sectors = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 70 * geo_track_sectors)
                                               : $urandom_range(0, 3 * geo_track_sectors);
         op      = ($urandom_range(0, 9) == 0) ? OP_INVALID : 2'($urandom_range(0, 2));
         kind    = $urandom_range(0, 99);
         if (kind < 80)
            send_at_sector(target, sectors, op);
         else if (kind < 90)
            send_request(48'({$urandom, $urandom} % 48'hFFFF_FFFF_FFFF + 48'd1),
                         31'(sectors * geo_sector_bytes), op);
         else
            send_request(48'({$urandom, $urandom}), 31'($urandom), 2'($urandom));
      end
   endtask

   initial begin
      reset           <= 1'b1;
      csr_write       <= 1'b0;
      csr_index       <= CSR_SECTOR_BYTES;
      csr_data        <= 32'd0;
      req_valid       <= 1'b0;
      req_byte_offset <= 48'd0;
      req_byte_count  <= 31'd0;
      req_operation   <= 2'd0;
      error_count     = 0;
      idle_cycles     = 0;
      stall_left      = 0;
      no_gaps         = 1'b0;
      geo_sector_bytes  = 16'd512;
      geo_track_sectors = 16'd63;
      geo_head_count    = 16'd255;
      geo_max_cylinder  = 16'd1023;
      geo_hidden_base   = 32'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_default_geometry();
      test_extreme_geometry();
      repeat (6) test_random_phase(56);

      wait_drained();
      repeat (300) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
